// ----- rtl/wbs_pkg.sv -----
package wbs_pkg;

	// Field widths of the pixel and drive channels.
	localparam int PIX_W   = 8;
	localparam int LIN_W   = 8;
	localparam int ANG_W   = 17;
	localparam int MODE_W  = 2;
	localparam int TCOL_W  = 10;
	localparam int TROW_W  = 10;
	localparam int TALLY_W = 21;

	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	// Configuration port.
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CUT_W     = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_WHITE_LEVEL  = 2'd2,
		REG_CUTOFF       = 2'd3
	} reg_index_t;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;
	localparam logic [PIX_W-1:0] WHITE_LEVEL_RST  = 8'd255;
	localparam logic [CUT_W-1:0] CUTOFF_RST       = 7'd70;

	// Q.8 drive values: 128 is one half, which is also 1 << DRIVE_SHIFT.
	localparam logic [LIN_W-1:0] DRIVE_HALF  = 8'd128;
	localparam int               DRIVE_SHIFT = 7;

	localparam logic [CUT_W-1:0] PCT_SCALE = 7'd100;

	// floor(x / 3) == (x * 0xAAAB) >> 17 for every x below 2**17.
	localparam int               RECIP_W     = 16;
	localparam logic [RECIP_W-1:0] THIRD_RECIP = 16'hAAAB;
	localparam int               THIRD_SHIFT = 17;

	typedef enum logic [MODE_W-1:0] {
		MODE_STOP     = 2'd0,
		MODE_LEFT     = 2'd1,
		MODE_STRAIGHT = 2'd2,
		MODE_RIGHT    = 2'd3
	} steer_mode_t;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_MUL_A   = 7'b0000010,
		ST_MUL_B   = 7'b0000100,
		ST_DECIDE  = 7'b0001000,
		ST_DIV     = 7'b0010000,
		ST_PUBLISH = 7'b0100000,
		ST_HOLD    = 7'b1000000
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic mul_a;
		logic mul_b;
		logic decide;
		logic div_step;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_status_t;

endpackage

// ----- rtl/wbs_pixel_if.sv -----
interface wbs_pixel_if;
	logic                       valid;
	logic                       ready;
	logic [wbs_pkg::PIX_W-1:0]  red;
	logic [wbs_pkg::PIX_W-1:0]  green;
	logic [wbs_pkg::PIX_W-1:0]  blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/wbs_drive_if.sv -----
interface wbs_drive_if;
	logic                               valid;
	logic                               ready;
	logic [wbs_pkg::LIN_W-1:0]          linear_drive;
	logic signed [wbs_pkg::ANG_W-1:0]   angular_drive;
	logic [wbs_pkg::MODE_W-1:0]         steer_mode;
	logic [wbs_pkg::TCOL_W-1:0]         target_col;
	logic [wbs_pkg::TROW_W-1:0]         target_row;
	logic [wbs_pkg::TALLY_W-1:0]        white_total;

	modport source (output valid, output linear_drive, output angular_drive, output steer_mode,
		output target_col, output target_row, output white_total, input ready);
	modport sink (input valid, input linear_drive, input angular_drive, input steer_mode,
		input target_col, input target_row, input white_total, output ready);
endinterface

// ----- rtl/wbs_scan.sv -----
module wbs_scan #(
	parameter int WB = 11,
	parameter int HB = 11,
	parameter int CW = 10,
	parameter int RW = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [wbs_pkg::PIX_W-1:0]   red,
	input  logic [wbs_pkg::PIX_W-1:0]   green,
	input  logic [wbs_pkg::PIX_W-1:0]   blue,
	input  logic [wbs_pkg::PIX_W-1:0]   white_level,
	input  logic [WB-1:0]               width,
	input  logic [HB-1:0]               height,
	output logic                        last,
	output logic                        snap_seen,
	output logic [CW-1:0]               snap_col,
	output logic [RW-1:0]               snap_row,
	output logic [wbs_pkg::TALLY_W-1:0] snap_tally
);

	localparam int CCW = WB + 1;
	localparam int RCW = HB + 1;

	logic [CW-1:0]               col_q;
	logic [RW-1:0]               row_q;
	logic                        seen_q;
	logic [CW-1:0]               hit_col_q;
	logic [RW-1:0]               hit_row_q;
	logic [wbs_pkg::TALLY_W-1:0] tally_q;

	logic col_end;
	logic row_end;
	logic is_white;
	logic first_hit;

	// A position at or past the last one within the size ends the row, so a shrunk size takes effect at once.
	assign col_end = !((CCW'(col_q) + CCW'(1)) < CCW'(width));
	assign row_end = !((RCW'(row_q) + RCW'(1)) < RCW'(height));
	assign last    = col_end && row_end;

	assign is_white  = (red == white_level) && (green == white_level) && (blue == white_level);
	assign first_hit = is_white && !seen_q;

	// Frame totals including the pixel now on the input.
	assign snap_seen  = seen_q || is_white;
	assign snap_col   = first_hit ? col_q : hit_col_q;
	assign snap_row   = first_hit ? row_q : hit_row_q;
	assign snap_tally = (is_white && (tally_q != wbs_pkg::TALLY_MAX)) ?
		tally_q + wbs_pkg::TALLY_W'(1) : tally_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			seen_q    <= 1'b0;
			hit_col_q <= '0;
			hit_row_q <= '0;
			tally_q   <= '0;
		end else if (accept) begin
			if (last) begin
				col_q     <= '0;
				row_q     <= '0;
				seen_q    <= 1'b0;
				hit_col_q <= '0;
				hit_row_q <= '0;
				tally_q   <= '0;
			end else begin
				seen_q    <= snap_seen;
				hit_col_q <= snap_col;
				hit_row_q <= snap_row;
				tally_q   <= snap_tally;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

endmodule

// ----- rtl/wbs_dpath.sv -----
module wbs_dpath #(
	parameter int WB = 11,
	parameter int HB = 11,
	parameter int CW = 10,
	parameter int RW = 10
) (
	input  logic                              clk,
	input  wbs_pkg::dp_cmd_t                  cmd,
	output wbs_pkg::dp_status_t               status,
	input  logic [WB-1:0]                     width,
	input  logic [HB-1:0]                     height,
	input  logic [wbs_pkg::CUT_W-1:0]         cutoff,
	input  logic                              snap_seen,
	input  logic [CW-1:0]                     snap_col,
	input  logic [RW-1:0]                     snap_row,
	input  logic [wbs_pkg::TALLY_W-1:0]       snap_tally,
	output logic [wbs_pkg::LIN_W-1:0]         linear_drive,
	output logic signed [wbs_pkg::ANG_W-1:0]  angular_drive,
	output logic [wbs_pkg::MODE_W-1:0]        steer_mode,
	output logic [wbs_pkg::TCOL_W-1:0]        target_col,
	output logic [wbs_pkg::TROW_W-1:0]        target_row,
	output logic [wbs_pkg::TALLY_W-1:0]       white_total
);

	localparam int WHW   = WB + HB;
	localparam int LHS_W = wbs_pkg::TALLY_W + wbs_pkg::CUT_W;
	localparam int RHS_W = wbs_pkg::CUT_W + WHW;
	localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
	localparam int TPW   = WB + wbs_pkg::RECIP_W;
	localparam int XW    = WB + 2;
	localparam int NW    = WB + wbs_pkg::DRIVE_SHIFT;
	localparam int CNT_W = $clog2(NW + 1);

	logic                        seen_q;
	logic [CW-1:0]               col_q;
	logic [RW-1:0]               row_q;
	logic [wbs_pkg::TALLY_W-1:0] tally_q;
	logic [WHW-1:0]              wh_q;
	logic [LHS_W-1:0]            lhs_q;
	logic [RHS_W-1:0]            rhs_q;
	logic [WB-1:0]               third_q;
	wbs_pkg::steer_mode_t        mode_q;
	logic [NW-1:0]               quo_q;
	logic [WB-1:0]               rem_q;
	logic [WB-1:0]               divisor_q;
	logic [CNT_W-1:0]            cnt_q;

	logic [TPW-1:0]        third_prod;
	logic                  stop;
	logic                  in_left;
	logic                  in_mid;
	wbs_pkg::steer_mode_t  mode_next;
	logic [WB:0]           rem_shift;
	logic                  rem_ge;

	assign third_prod = TPW'(width) * TPW'(wbs_pkg::THIRD_RECIP);

	assign stop    = !seen_q || !(CMP_W'(lhs_q) < CMP_W'(rhs_q));
	assign in_left = XW'(col_q) < XW'(third_q);
	assign in_mid  = XW'(col_q) < (XW'(third_q) << 1);

	always_comb begin
		if (stop) begin
			mode_next = wbs_pkg::MODE_STOP;
		end else if (in_left) begin
			mode_next = wbs_pkg::MODE_LEFT;
		end else if (in_mid) begin
			mode_next = wbs_pkg::MODE_STRAIGHT;
		end else begin
			mode_next = wbs_pkg::MODE_RIGHT;
		end
	end

	// One quotient bit per step of a restoring divider; the remainder stays below the divisor.
	assign rem_shift = {rem_q, quo_q[NW-1]};
	assign rem_ge    = rem_shift >= {1'b0, divisor_q};

	assign status.need_div = (mode_q == wbs_pkg::MODE_LEFT) || (mode_q == wbs_pkg::MODE_RIGHT);
	assign status.div_done = cnt_q == CNT_W'(NW);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seen_q  <= snap_seen;
			col_q   <= snap_col;
			row_q   <= snap_row;
			tally_q <= snap_tally;
		end
		if (cmd.mul_a) begin
			wh_q  <= WHW'(width) * WHW'(height);
			lhs_q <= LHS_W'(tally_q) * LHS_W'(wbs_pkg::PCT_SCALE);
		end
		if (cmd.mul_b) begin
			rhs_q   <= RHS_W'(cutoff) * RHS_W'(wh_q);
			third_q <= WB'(third_prod >> wbs_pkg::THIRD_SHIFT);
		end
		if (cmd.decide) begin
			mode_q <= mode_next;
			rem_q  <= '0;
			cnt_q  <= '0;
			if (in_left) begin
				quo_q     <= {third_q, {wbs_pkg::DRIVE_SHIFT{1'b0}}};
				divisor_q <= WB'(col_q) + WB'(1);
			end else begin
				quo_q     <= {WB'(col_q), {wbs_pkg::DRIVE_SHIFT{1'b0}}};
				divisor_q <= width;
			end
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? WB'(rem_shift - {1'b0, divisor_q}) : rem_shift[WB-1:0];
			quo_q <= {quo_q[NW-2:0], rem_ge};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.publish) begin
			steer_mode  <= mode_q;
			target_col  <= wbs_pkg::TCOL_W'(col_q);
			target_row  <= wbs_pkg::TROW_W'(row_q);
			white_total <= tally_q;
			case (mode_q)
				wbs_pkg::MODE_LEFT: begin
					linear_drive  <= wbs_pkg::DRIVE_HALF;
					angular_drive <= $signed(wbs_pkg::ANG_W'(quo_q));
				end
				wbs_pkg::MODE_STRAIGHT: begin
					linear_drive  <= wbs_pkg::DRIVE_HALF;
					angular_drive <= '0;
				end
				wbs_pkg::MODE_RIGHT: begin
					linear_drive  <= wbs_pkg::DRIVE_HALF;
					angular_drive <= $signed(wbs_pkg::ANG_W'(0) - wbs_pkg::ANG_W'(quo_q));
				end
				default: begin
					linear_drive  <= '0;
					angular_drive <= '0;
				end
			endcase
		end
	end

endmodule

// ----- rtl/wbs_ctrl.sv -----
module wbs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_done,
	input  logic                out_ready,
	input  wbs_pkg::dp_status_t status,
	output wbs_pkg::dp_cmd_t    cmd,
	output logic                idle,
	output logic                out_valid
);

	wbs_pkg::ctrl_state_t state_q;
	wbs_pkg::ctrl_state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			wbs_pkg::ST_IDLE: begin
				if (frame_done) begin
					state_d = wbs_pkg::ST_MUL_A;
				end
			end
			wbs_pkg::ST_MUL_A: begin
				state_d = wbs_pkg::ST_MUL_B;
			end
			wbs_pkg::ST_MUL_B: begin
				state_d = wbs_pkg::ST_DECIDE;
			end
			wbs_pkg::ST_DECIDE: begin
				state_d = wbs_pkg::ST_DIV;
			end
			wbs_pkg::ST_DIV: begin
				if (!status.need_div || status.div_done) begin
					state_d = wbs_pkg::ST_PUBLISH;
				end
			end
			wbs_pkg::ST_PUBLISH: begin
				state_d = wbs_pkg::ST_HOLD;
			end
			wbs_pkg::ST_HOLD: begin
				if (out_ready) begin
					state_d = wbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign idle      = state_q == wbs_pkg::ST_IDLE;
	assign out_valid = state_q == wbs_pkg::ST_HOLD;

	assign cmd.load     = frame_done && idle;
	assign cmd.mul_a    = state_q == wbs_pkg::ST_MUL_A;
	assign cmd.mul_b    = state_q == wbs_pkg::ST_MUL_B;
	assign cmd.decide   = state_q == wbs_pkg::ST_DECIDE;
	assign cmd.div_step = (state_q == wbs_pkg::ST_DIV) && status.need_div && !status.div_done;
	assign cmd.publish  = state_q == wbs_pkg::ST_PUBLISH;

endmodule

// ----- rtl/white_blob_steering_top.sv -----
// Pixels transfer at one per cycle; only a frame's last pixel waits until the previous
// drive result has been taken.
// A result passes from the last pixel through the MUL_A, MUL_B, DECIDE, DIV and PUBLISH
// states and is then held as valid; for left and right, DIV runs the one-bit-per-cycle
// divider that forms the angular drive, while stop and straight skip the division.
// Reset (arst_n low, asynchronous) restores the default registers and starts a new frame.
module white_blob_steering_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wbs_pkg::CFG_W-1:0]     cfg_data,
	wbs_pixel_if.sink                     pixel,
	wbs_drive_if.source                   drive
);

	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int HB = $clog2(MAX_HEIGHT + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	logic [wbs_pkg::CFG_W-1:0] frame_width_q;
	logic [wbs_pkg::CFG_W-1:0] frame_height_q;
	logic [wbs_pkg::PIX_W-1:0] white_level_q;
	logic [wbs_pkg::CUT_W-1:0] cutoff_q;

	logic [WB-1:0]               width_eff;
	logic [HB-1:0]               height_eff;
	logic                        accept;
	logic                        last;
	logic                        frame_done;
	logic                        idle;
	logic                        snap_seen;
	logic [CW-1:0]               snap_col;
	logic [RW-1:0]               snap_row;
	logic [wbs_pkg::TALLY_W-1:0] snap_tally;
	wbs_pkg::dp_cmd_t            cmd;
	wbs_pkg::dp_status_t         status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= wbs_pkg::FRAME_WIDTH_RST;
			frame_height_q <= wbs_pkg::FRAME_HEIGHT_RST;
			white_level_q  <= wbs_pkg::WHITE_LEVEL_RST;
			cutoff_q       <= wbs_pkg::CUTOFF_RST;
		end else if (cfg_we) begin
			case (wbs_pkg::reg_index_t'(cfg_index))
				wbs_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				wbs_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				wbs_pkg::REG_WHITE_LEVEL:  white_level_q  <= cfg_data[wbs_pkg::PIX_W-1:0];
				wbs_pkg::REG_CUTOFF:       cutoff_q       <= cfg_data[wbs_pkg::CUT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A zero size acts as one; an oversized one saturates at the maximum.
	assign width_eff = (frame_width_q == '0) ? WB'(1) :
		((32'(frame_width_q) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(frame_width_q));
	assign height_eff = (frame_height_q == '0) ? HB'(1) :
		((32'(frame_height_q) > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : HB'(frame_height_q));

	assign pixel.ready = !last || idle;
	assign accept      = pixel.valid && pixel.ready;
	assign frame_done  = accept && last;

	wbs_scan #(.WB(WB), .HB(HB), .CW(CW), .RW(RW)) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.red         (pixel.red),
		.green       (pixel.green),
		.blue        (pixel.blue),
		.white_level (white_level_q),
		.width       (width_eff),
		.height      (height_eff),
		.last        (last),
		.snap_seen   (snap_seen),
		.snap_col    (snap_col),
		.snap_row    (snap_row),
		.snap_tally  (snap_tally)
	);

	wbs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_done (frame_done),
		.out_ready  (drive.ready),
		.status     (status),
		.cmd        (cmd),
		.idle       (idle),
		.out_valid  (drive.valid)
	);

	wbs_dpath #(.WB(WB), .HB(HB), .CW(CW), .RW(RW)) u_dpath (
		.clk           (clk),
		.cmd           (cmd),
		.status        (status),
		.width         (width_eff),
		.height        (height_eff),
		.cutoff        (cutoff_q),
		.snap_seen     (snap_seen),
		.snap_col      (snap_col),
		.snap_row      (snap_row),
		.snap_tally    (snap_tally),
		.linear_drive  (drive.linear_drive),
		.angular_drive (drive.angular_drive),
		.steer_mode    (drive.steer_mode),
		.target_col    (drive.target_col),
		.target_row    (drive.target_row),
		.white_total   (drive.white_total)
	);

endmodule

// ----- rtl/wbs_checker.sv -----
module wbs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              drive_valid,
	input logic                              drive_ready,
	input logic [wbs_pkg::LIN_W-1:0]         linear_drive,
	input logic signed [wbs_pkg::ANG_W-1:0]  angular_drive,
	input logic [wbs_pkg::MODE_W-1:0]        steer_mode,
	input logic [wbs_pkg::TCOL_W-1:0]        target_col,
	input logic [wbs_pkg::TROW_W-1:0]        target_row,
	input logic [wbs_pkg::TALLY_W-1:0]       white_total
);

	// A result that is not taken stays on the channel unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && !drive_ready |=> drive_valid && $stable(linear_drive) &&
		$stable(angular_drive) && $stable(steer_mode) && $stable(target_col) &&
		$stable(target_row) && $stable(white_total))
	else $error("drive result changed while stalled");

	// Forward speed is zero exactly for a stop, and a stop never turns.
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> ((linear_drive == '0) == (steer_mode == wbs_pkg::MODE_STOP)) &&
		((steer_mode != wbs_pkg::MODE_STOP) || (angular_drive == '0)))
	else $error("linear drive disagrees with steer mode");

	// A right turn is the negated share of the column, so it lies in (-128, 0].
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && (steer_mode == wbs_pkg::MODE_RIGHT) |->
		(angular_drive <= 0) && (angular_drive > -128))
	else $error("right turn out of range");

	// A frame with no white pixel stops and reports no target.
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && (white_total == '0) |->
		(steer_mode == wbs_pkg::MODE_STOP) && (target_col == '0) && (target_row == '0))
	else $error("empty frame did not stop cleanly");

endmodule

bind white_blob_steering_top wbs_checker u_wbs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.drive_valid   (drive.valid),
	.drive_ready   (drive.ready),
	.linear_drive  (drive.linear_drive),
	.angular_drive (drive.angular_drive),
	.steer_mode    (drive.steer_mode),
	.target_col    (drive.target_col),
	.target_row    (drive.target_row),
	.white_total   (drive.white_total)
);
